[sv/triangle_tangent_basis_macros.svh]
// Assertion macros for the triangle tangent basis controller.
// No dependencies; included by files that carry concurrent assertions.
`ifndef TRIANGLE_TANGENT_BASIS_MACROS_SVH
`define TRIANGLE_TANGENT_BASIS_MACROS_SVH

// same-cycle implication
`define TTB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ttb assertion failed");

// next-cycle implication
`define TTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ttb assertion failed");

`endif

[sv/ttb_pkg.sv]
// Package for the triangle tangent basis block: controller states, command and status types.
// No dependencies.
`timescale 1ns / 1ps
package ttb_pkg;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START_A,
      S_RUN_A,
      S_START_B,
      S_RUN_B,
      S_DET,
      S_START_D,
      S_RUN_D,
      S_EMIT
   } state_type;

   localparam logic [2:0] SEL_DET    = 3'd0;
   localparam logic [2:0] SEL_TAN_X  = 3'd1;
   localparam logic [2:0] SEL_TAN_Y  = 3'd2;
   localparam logic [2:0] SEL_TAN_Z  = 3'd3;
   localparam logic [2:0] SEL_BIT_X  = 3'd4;
   localparam logic [2:0] SEL_BIT_Y  = 3'd5;
   localparam logic [2:0] SEL_BIT_Z  = 3'd6;
   localparam logic [1:0] LAST_CORNER = 2'd2;

   typedef struct packed {
      logic       store0;
      logic       store1;
      logic       delta_load;
      logic       mul_start;
      logic       half;
      logic       det_latch;
      logic       div_start;
      logic [2:0] sel;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic det_zero;
   } status_type;

endpackage

[sv/ttb_req_if.sv]
// Vertex input channel: valid/ready handshake with position and texture payload.
// No dependencies.
`timescale 1ns / 1ps
interface ttb_req_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] pos_x;
   logic signed [COORD_WIDTH-1:0] pos_y;
   logic signed [COORD_WIDTH-1:0] pos_z;
   logic signed [COORD_WIDTH-1:0] tex_u;
   logic signed [COORD_WIDTH-1:0] tex_v;
   modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

[sv/ttb_rsp_if.sv]
// Result channel: valid/ready handshake with tangent, bitangent and flags.
// No dependencies.
`timescale 1ns / 1ps
interface ttb_rsp_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    corner;
   logic signed [COORD_WIDTH-1:0] tan_x;
   logic signed [COORD_WIDTH-1:0] tan_y;
   logic signed [COORD_WIDTH-1:0] tan_z;
   logic signed [COORD_WIDTH-1:0] bitan_x;
   logic signed [COORD_WIDTH-1:0] bitan_y;
   logic signed [COORD_WIDTH-1:0] bitan_z;
   logic                          degenerate;
   logic                          last;
   modport source (output valid, corner, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
                   degenerate, last, input ready);
   modport sink (input valid, corner, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
                 degenerate, last, output ready);
endinterface

[sv/ttb_controller.sv]
// Sequencer for the triangle tangent basis: corner counting, product/divide steps, emission.
// Depends on ttb_pkg and triangle_tangent_basis_macros.svh.
`timescale 1ns / 1ps
`include "triangle_tangent_basis_macros.svh"
module ttb_controller
   import ttb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_corner,
   output logic       rsp_last,
   output cmd_type    cmd,
   input  status_type status
);

   state_type  state_ff, state_in;
   logic [1:0] count_ff, count_in;
   logic [2:0] sel_ff, sel_in;
   logic [1:0] copy_ff, copy_in;
   logic       accept;

   assign accept = req_valid && (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         sel_ff   <= '0;
         copy_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sel_ff   <= sel_in;
         copy_ff  <= copy_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:    if (accept && count_ff == LAST_CORNER) state_in = S_START_A;
         S_START_A: state_in = S_RUN_A;
         S_RUN_A:   if (status.mul_done) state_in = S_START_B;
         S_START_B: state_in = S_RUN_B;
         S_RUN_B: begin
            if (status.mul_done) state_in = (sel_ff == SEL_DET) ? S_DET : S_START_D;
         end
         S_DET:     state_in = status.det_zero ? S_EMIT : S_START_A;
         S_START_D: state_in = S_RUN_D;
         S_RUN_D: begin
            if (status.div_done) state_in = (sel_ff == SEL_BIT_Z) ? S_EMIT : S_START_A;
         end
         S_EMIT:    if (rsp_ready && copy_ff == LAST_CORNER) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      sel_in   = sel_ff;
      copy_in  = copy_ff;
      if (accept) begin
         count_in = (count_ff == LAST_CORNER) ? 2'd0 : count_ff + 2'd1;
         sel_in   = SEL_DET;
         copy_in  = 2'd0;
      end
      if (state_ff == S_DET) sel_in = SEL_TAN_X;
      if (state_ff == S_RUN_D && status.div_done) sel_in = sel_ff + 3'd1;
      if (state_ff == S_EMIT && rsp_ready) copy_in = copy_ff + 2'd1;
   end

   always_comb begin
      req_ready      = (state_ff == S_IDLE);
      cmd.store0     = accept && (count_ff == 2'd0);
      cmd.store1     = accept && (count_ff == 2'd1);
      cmd.delta_load = accept && (count_ff == LAST_CORNER);
      cmd.mul_start  = (state_ff == S_START_A) || (state_ff == S_START_B);
      cmd.half       = (state_ff == S_START_B);
      cmd.det_latch  = (state_ff == S_DET);
      cmd.div_start  = (state_ff == S_START_D);
      cmd.sel        = sel_ff;
      rsp_valid      = (state_ff == S_EMIT);
      rsp_corner     = copy_ff;
      rsp_last       = (copy_ff == LAST_CORNER);
   end

   `TTB_ASSERT_NOW(a_mul_done_in_run, clock, reset, status.mul_done,
                   state_ff == S_RUN_A || state_ff == S_RUN_B)
   `TTB_ASSERT_NOW(a_div_done_in_run, clock, reset, status.div_done, state_ff == S_RUN_D)
   `TTB_ASSERT_NEXT(a_last_to_idle, clock, reset, rsp_valid && rsp_ready && rsp_last,
                    state_ff == S_IDLE)

endmodule

[sv/ttb_datapath.sv]
// Datapath: held corners, deltas, serial multiply-accumulate, restoring divider, results.
// Depends on ttb_pkg.
`timescale 1ns / 1ps
module ttb_datapath
   import ttb_pkg::*;
#(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output status_type                    status,
   input  logic signed [COORD_WIDTH-1:0] pos_x,
   input  logic signed [COORD_WIDTH-1:0] pos_y,
   input  logic signed [COORD_WIDTH-1:0] pos_z,
   input  logic signed [COORD_WIDTH-1:0] tex_u,
   input  logic signed [COORD_WIDTH-1:0] tex_v,
   output logic signed [COORD_WIDTH-1:0] tan_x,
   output logic signed [COORD_WIDTH-1:0] tan_y,
   output logic signed [COORD_WIDTH-1:0] tan_z,
   output logic signed [COORD_WIDTH-1:0] bitan_x,
   output logic signed [COORD_WIDTH-1:0] bitan_y,
   output logic signed [COORD_WIDTH-1:0] bitan_z,
   output logic                          degenerate
);

   localparam int W   = COORD_WIDTH;
   localparam int NW  = W + 1;
   localparam int AW  = 2 * W + 3;
   localparam int DW  = 2 * W + 2;
   localparam int DN  = DW + FRAC_BITS;
   localparam int MCW = $clog2(NW);
   localparam int DCW = $clog2(DN + 1);
   localparam logic [NW:0]  LIM     = (NW + 1)'(1) << (W - 1);
   localparam logic [W-1:0] POS_MAX = {1'b0, {(W - 1){1'b1}}};
   localparam logic [W-1:0] NEG_MIN = {1'b1, {(W - 1){1'b0}}};

   logic signed [W-1:0]  hp0_ff [3];
   logic signed [W-1:0]  hp1_ff [3];
   logic signed [W-1:0]  ht0_ff [2];
   logic signed [W-1:0]  ht1_ff [2];
   logic signed [W-1:0]  in_pos [3];
   logic signed [NW-1:0] dp1_ff [3];
   logic signed [NW-1:0] dp2_ff [3];
   logic signed [NW-1:0] du1_ff, dv1_ff, du2_ff, dv2_ff;

   logic signed [NW-1:0] mul_a, mul_b;
   logic signed [AW-1:0] mc_ff, acc_ff, det_ff, term;
   logic [NW-1:0]        mp_ff;
   logic [MCW-1:0]       mcnt_ff;
   logic                 msub_ff, mbusy_ff, mneg, mlast;

   logic [AW-1:0]  acc_abs, det_abs;
   logic [DN-1:0]  nsh_ff;
   logic [DW-1:0]  den_ff, rem_ff;
   logic [NW-1:0]  q_ff;
   logic [DCW-1:0] dcnt_ff;
   logic [2:0]     dsel_ff, widx;
   logic           dneg_ff, ovf_ff, dbusy_ff, degen_ff;
   logic [DW:0]    r2, rr;
   logic           ge, rup;
   logic [NW:0]    qr;
   logic [W-1:0]   qneg, quot;
   logic signed [W-1:0] res_ff [6];

   assign in_pos[0] = pos_x;
   assign in_pos[1] = pos_y;
   assign in_pos[2] = pos_z;

   always_ff @(posedge clock) begin
      if (cmd.store0) begin
         for (int a = 0; a < 3; a++) hp0_ff[a] <= in_pos[a];
         ht0_ff[0] <= tex_u;
         ht0_ff[1] <= tex_v;
      end
      if (cmd.store1) begin
         for (int a = 0; a < 3; a++) hp1_ff[a] <= in_pos[a];
         ht1_ff[0] <= tex_u;
         ht1_ff[1] <= tex_v;
      end
      if (cmd.delta_load) begin
         for (int a = 0; a < 3; a++) begin
            dp1_ff[a] <= NW'(hp1_ff[a]) - NW'(hp0_ff[a]);
            dp2_ff[a] <= NW'(in_pos[a]) - NW'(hp0_ff[a]);
         end
         du1_ff <= NW'(ht1_ff[0]) - NW'(ht0_ff[0]);
         dv1_ff <= NW'(ht1_ff[1]) - NW'(ht0_ff[1]);
         du2_ff <= NW'(tex_u) - NW'(ht0_ff[0]);
         dv2_ff <= NW'(tex_v) - NW'(ht0_ff[1]);
      end
   end

   always_comb begin
      case (cmd.sel)
         SEL_DET:   begin mul_a = cmd.half ? dv1_ff : du1_ff;       mul_b = cmd.half ? du2_ff : dv2_ff; end
         SEL_TAN_X: begin mul_a = cmd.half ? dp2_ff[0] : dp1_ff[0]; mul_b = cmd.half ? dv1_ff : dv2_ff; end
         SEL_TAN_Y: begin mul_a = cmd.half ? dp2_ff[1] : dp1_ff[1]; mul_b = cmd.half ? dv1_ff : dv2_ff; end
         SEL_TAN_Z: begin mul_a = cmd.half ? dp2_ff[2] : dp1_ff[2]; mul_b = cmd.half ? dv1_ff : dv2_ff; end
         SEL_BIT_X: begin mul_a = cmd.half ? dp1_ff[0] : dp2_ff[0]; mul_b = cmd.half ? du2_ff : du1_ff; end
         SEL_BIT_Y: begin mul_a = cmd.half ? dp1_ff[1] : dp2_ff[1]; mul_b = cmd.half ? du2_ff : du1_ff; end
         SEL_BIT_Z: begin mul_a = cmd.half ? dp1_ff[2] : dp2_ff[2]; mul_b = cmd.half ? du2_ff : du1_ff; end
         default:   begin mul_a = '0;                               mul_b = '0;                     end
      endcase
   end

   // shift-add multiply, one multiplier bit per cycle; the sign bit weighs negative
   assign mlast = (mcnt_ff == MCW'(NW - 1));
   assign mneg  = msub_ff ^ mlast;
   assign term  = mp_ff[0] ? mc_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
      end else if (cmd.mul_start) begin
         mbusy_ff <= 1'b1;
      end else if (mbusy_ff && mlast) begin
         mbusy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_start) begin
         mc_ff   <= AW'(mul_a);
         mp_ff   <= mul_b;
         mcnt_ff <= '0;
         msub_ff <= cmd.half;
         if (!cmd.half) acc_ff <= '0;
      end else if (mbusy_ff) begin
         acc_ff  <= mneg ? acc_ff - term : acc_ff + term;
         mc_ff   <= mc_ff <<< 1;
         mp_ff   <= mp_ff >> 1;
         mcnt_ff <= mcnt_ff + MCW'(1);
      end
      if (cmd.det_latch) det_ff <= acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         degen_ff <= 1'b0;
      end else if (cmd.det_latch) begin
         degen_ff <= (acc_ff == '0);
      end
   end

   // restoring division of |num| * 2^FRAC_BITS by |det|, then round and saturate
   assign acc_abs = acc_ff[AW-1] ? AW'(-acc_ff) : AW'(acc_ff);
   assign det_abs = det_ff[AW-1] ? AW'(-det_ff) : AW'(det_ff);
   assign r2      = {rem_ff, nsh_ff[DN-1]};
   assign ge      = (r2 >= {1'b0, den_ff});
   assign rr      = {rem_ff, 1'b0};
   assign rup     = (rr >= {1'b0, den_ff});
   assign qr      = {1'b0, q_ff} + (NW + 1)'(rup);
   assign qneg    = -qr[W-1:0];
   assign widx    = dsel_ff - 3'd1;

   always_comb begin
      if (!dneg_ff) quot = (ovf_ff || qr > LIM - (NW + 1)'(1)) ? POS_MAX : qr[W-1:0];
      else          quot = (ovf_ff || qr > LIM) ? NEG_MIN : qneg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         dbusy_ff <= 1'b1;
      end else if (dbusy_ff && dcnt_ff == DCW'(DN)) begin
         dbusy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dneg_ff <= acc_ff[AW-1] ^ det_ff[AW-1];
         den_ff  <= det_abs[DW-1:0];
         nsh_ff  <= {acc_abs[DW-1:0], {FRAC_BITS{1'b0}}};
         rem_ff  <= '0;
         q_ff    <= '0;
         ovf_ff  <= 1'b0;
         dcnt_ff <= '0;
         dsel_ff <= cmd.sel;
      end else if (dbusy_ff) begin
         if (dcnt_ff != DCW'(DN)) begin
            rem_ff  <= ge ? DW'(r2 - {1'b0, den_ff}) : DW'(r2);
            q_ff    <= {q_ff[NW-2:0], ge};
            ovf_ff  <= ovf_ff | q_ff[NW-1];
            nsh_ff  <= nsh_ff << 1;
            dcnt_ff <= dcnt_ff + DCW'(1);
         end else begin
            res_ff[widx] <= quot;
         end
      end
   end

   assign status.mul_done = mbusy_ff && mlast;
   assign status.div_done = dbusy_ff && (dcnt_ff == DCW'(DN));
   assign status.det_zero = (acc_ff == '0);

   assign tan_x      = degen_ff ? '0 : res_ff[0];
   assign tan_y      = degen_ff ? '0 : res_ff[1];
   assign tan_z      = degen_ff ? '0 : res_ff[2];
   assign bitan_x    = degen_ff ? '0 : res_ff[3];
   assign bitan_y    = degen_ff ? '0 : res_ff[4];
   assign bitan_z    = degen_ff ? '0 : res_ff[5];
   assign degenerate = degen_ff;

endmodule

[sv/triangle_tangent_basis.sv]
// Triangle tangent basis: the first two corners are only held; the third starts the work.
// From the third corner: two serial products for the determinant, a determinant check, then
// for each of the six outputs two serial products and a restoring division, in Q16.16 at the
// defaults. A zero determinant skips to the results. Results leave one a cycle when ready.
// Synchronous active-high reset clears the controller, busy and degenerate flags, not held data.
`timescale 1ns / 1ps
module triangle_tangent_basis
   import ttb_pkg::*;
#(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input logic       clock,
   input logic       reset,
   ttb_req_if.sink   req_chan,
   ttb_rsp_if.source rsp_chan
);

   cmd_type    cmd;
   status_type status;

   ttb_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_corner (rsp_chan.corner),
      .rsp_last   (rsp_chan.last),
      .cmd        (cmd),
      .status     (status)
   );

   ttb_datapath #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .pos_x      (req_chan.pos_x),
      .pos_y      (req_chan.pos_y),
      .pos_z      (req_chan.pos_z),
      .tex_u      (req_chan.tex_u),
      .tex_v      (req_chan.tex_v),
      .tan_x      (rsp_chan.tan_x),
      .tan_y      (rsp_chan.tan_y),
      .tan_z      (rsp_chan.tan_z),
      .bitan_x    (rsp_chan.bitan_x),
      .bitan_y    (rsp_chan.bitan_y),
      .bitan_z    (rsp_chan.bitan_z),
      .degenerate (rsp_chan.degenerate)
   );

endmodule

[verif/triangle_tangent_basis_tb.sv]
// Testbench for triangle_tangent_basis: drives vertex transactions, predicts face tangents.
// Depends on ttb_pkg, ttb_req_if, ttb_rsp_if and the triangle_tangent_basis RTL.
`timescale 1ns / 1ps
module triangle_tangent_basis_tb;
   import ttb_pkg::*;

   typedef struct {
      logic [1:0]         corner;
      logic signed [31:0] tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z;
      logic               degenerate, last;
   } basis_type;

   class basis_scoreboard;
      logic signed [31:0] held_pos[6];
      logic signed [31:0] held_tex[4];
      int                 corners_held;
      basis_type          pending[$];
      int                 errors;

      function new();
         corners_held = 0;
         errors = 0;
      endfunction

      // num * 2^16 / den, rounded half away from zero, saturated to 32 bits
      function logic signed [31:0] scaled_quotient(logic signed [127:0] num,
                                                   logic signed [127:0] den);
         logic         neg;
         logic [127:0] n, d, q, r;
         neg = (num < 0) != (den < 0);
         n = (num < 0) ? -num : num;
         d = (den < 0) ? -den : den;
         n = n << 16;
         q = n / d;
         r = n % d;
         if ((r << 1) >= d) q = q + 1;
         if (!neg) return (q > 128'h7fffffff) ? 32'sh7fffffff : q[31:0];
         if (q > 128'h80000000) return 32'sh80000000;
         return -q[31:0];
      endfunction

      function void note_vertex(logic signed [31:0] p[3], logic signed [31:0] u,
                                logic signed [31:0] v);
         logic signed [127:0] dp1[3], dp2[3], du1, dv1, du2, dv2, det;
         basis_type           res;
         if (corners_held < 2) begin
            for (int a = 0; a < 3; a++) held_pos[corners_held*3+a] = p[a];
            held_tex[corners_held*2] = u;
            held_tex[corners_held*2+1] = v;
            corners_held++;
            return;
         end
         for (int a = 0; a < 3; a++) begin
            dp1[a] = 128'(held_pos[3+a]) - 128'(held_pos[a]);
            dp2[a] = 128'(p[a]) - 128'(held_pos[a]);
         end
         du1 = 128'(held_tex[2]) - 128'(held_tex[0]);
         dv1 = 128'(held_tex[3]) - 128'(held_tex[1]);
         du2 = 128'(u) - 128'(held_tex[0]);
         dv2 = 128'(v) - 128'(held_tex[1]);
         det = du1 * dv2 - dv1 * du2;
         res.degenerate = (det == 0);
         if (res.degenerate) begin
            {res.tan_x, res.tan_y, res.tan_z} = '0;
            {res.bitan_x, res.bitan_y, res.bitan_z} = '0;
         end else begin
            res.tan_x = scaled_quotient(dp1[0] * dv2 - dp2[0] * dv1, det);
            res.tan_y = scaled_quotient(dp1[1] * dv2 - dp2[1] * dv1, det);
            res.tan_z = scaled_quotient(dp1[2] * dv2 - dp2[2] * dv1, det);
            res.bitan_x = scaled_quotient(dp2[0] * du1 - dp1[0] * du2, det);
            res.bitan_y = scaled_quotient(dp2[1] * du1 - dp1[1] * du2, det);
            res.bitan_z = scaled_quotient(dp2[2] * du1 - dp1[2] * du2, det);
         end
         for (int k = 0; k < 3; k++) begin
            res.corner = 2'(k);
            res.last = (k == LAST_CORNER);
            pending.insert(pending.size(), res);
         end
         corners_held = 0;
      endfunction

      function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_basis(basis_type act);
         basis_type exp_r;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual corner %0d", $time,
                     act.corner);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         check_field("corner", 32'(exp_r.corner), 32'(act.corner));
         check_field("tan_x", exp_r.tan_x, act.tan_x);
         check_field("tan_y", exp_r.tan_y, act.tan_y);
         check_field("tan_z", exp_r.tan_z, act.tan_z);
         check_field("bitan_x", exp_r.bitan_x, act.bitan_x);
         check_field("bitan_y", exp_r.bitan_y, act.bitan_y);
         check_field("bitan_z", exp_r.bitan_z, act.bitan_z);
         check_field("degenerate", 32'(exp_r.degenerate), 32'(act.degenerate));
         check_field("last", 32'(exp_r.last), 32'(act.last));
      endfunction
   endclass

   logic clock, reset;
   ttb_req_if #(.COORD_WIDTH(32)) req_chan ();
   ttb_rsp_if #(.COORD_WIDTH(32)) rsp_chan ();

   triangle_tangent_basis uut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   basis_scoreboard board = new();
   int  hold_off_cycles = 0;
   int  rsp_gap = 0;
   bit  driving_done = 0;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [31:0] u, logic [31:0] v);
      logic signed [31:0] p[3];
      int                 gap;
      req_chan.valid <= 1'b1;
      req_chan.pos_x <= x;
      req_chan.pos_y <= y;
      req_chan.pos_z <= z;
      req_chan.tex_u <= u;
      req_chan.tex_v <= v;
      do @(posedge clock); while (!req_chan.ready);
      p[0] = x;
      p[1] = y;
      p[2] = z;
      board.note_vertex(p, u, v);
      @(negedge clock);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom;
         default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      endcase
   endfunction

   task automatic send_triangle(bit flat_uv);
      logic [31:0] u0, v0;
      u0 = pick_coord();
      v0 = pick_coord();
      for (int c = 0; c < 3; c++) begin
         if (flat_uv) send_vertex(pick_coord(), pick_coord(), pick_coord(), u0, v0 + c);
         else send_vertex(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                          pick_coord());
      end
   endtask

   task automatic wait_drained();
      while (board.pending.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // drop valid, then hold until every expected result has come
   task automatic drain_input();
      req_chan.valid <= 1'b0;
      wait_drained();
   endtask

   // receiver: per-transaction stall, plus a long hold-off when requested
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap = rsp_gap - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      basis_type act;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         act.corner = rsp_chan.corner;
         act.tan_x = rsp_chan.tan_x;
         act.tan_y = rsp_chan.tan_y;
         act.tan_z = rsp_chan.tan_z;
         act.bitan_x = rsp_chan.bitan_x;
         act.bitan_y = rsp_chan.bitan_y;
         act.bitan_z = rsp_chan.bitan_z;
         act.degenerate = rsp_chan.degenerate;
         act.last = rsp_chan.last;
         board.check_basis(act);
         rsp_gap = $urandom_range(0, 5);
      end
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.pos_x = '0;
      req_chan.pos_y = '0;
      req_chan.pos_z = '0;
      req_chan.tex_u = '0;
      req_chan.tex_v = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // unit right triangle in UV space
      send_vertex(0, 0, 0, 0, 0);
      send_vertex(32'h10000, 0, 0, 32'h10000, 0);
      send_vertex(0, 32'h10000, 0, 0, 32'h10000);
      // degenerate: identical UVs
      send_vertex(32'h7fffffff, 32'h80000000, 5, 32'h30000, 32'h30000);
      send_vertex(1, 2, 3, 32'h30000, 32'h30000);
      send_vertex(4, 5, 6, 32'h30000, 32'h30000);
      // saturation: extreme positions over a tiny determinant
      send_vertex(32'h80000000, 32'h80000000, 32'h80000000, 0, 0);
      send_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 0);
      send_vertex(32'h7fffffff, 32'h80000000, 0, 0, 1);
      // extreme texture coordinates
      send_vertex(32'hffffffff, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
      send_vertex(0, 32'hffffffff, 1, 32'h7fffffff, 32'h80000000);
      send_vertex(32'h12345678, 32'hedcba987, 0, 32'h80000000, 32'h80000000);
      // tie in rounding: quotient of exactly one half unit
      send_vertex(0, 0, 0, 0, 0);
      send_vertex(1, 0, 0, 32'h20000, 0);
      send_vertex(0, 0, 0, 0, 32'h10000);
      drain_input();
      for (int t = 0; t < 95; t++) begin
         if (t == 30) hold_off_cycles = 6000;
         if (t == 60) drain_input();
         send_triangle($urandom_range(0, 9) == 0);
      end
      req_chan.valid <= 1'b0;
      driving_done = 1;
   end

   initial begin
      wait (driving_done);
      wait_drained();
      repeat (1200) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("triangle_tangent_basis_tb: PASS");
      end else begin
         $display("triangle_tangent_basis_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("triangle_tangent_basis_tb: FAIL");
      $finish;
   end
endmodule

[triangle_tangent_basis.f]
+incdir+sv
sv/ttb_pkg.sv
sv/ttb_req_if.sv
sv/ttb_rsp_if.sv
sv/ttb_controller.sv
sv/ttb_datapath.sv
sv/triangle_tangent_basis.sv
verif/triangle_tangent_basis_tb.sv
